>>> src/idt_pkg.sv
package idt_pkg;

	// Fixed field widths
	localparam int unsigned DATA_W   = 64;
	localparam int unsigned INDEX_W  = 6;
	localparam int unsigned REQ_W    = 3;
	localparam int unsigned STATUS_W = 2;

	// Default capacity of the ring
	localparam int unsigned DEPTH_DEF = 64;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_READ       = 3'd0,
		REQ_WRITE      = 3'd1,
		REQ_PUSH_FRONT = 3'd2,
		REQ_PUSH_BACK  = 3'd3,
		REQ_POP_FRONT  = 3'd4,
		REQ_POP_BACK   = 3'd5
	} req_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Result control handed from the controller to the output stage
	typedef struct packed {
		logic    done;
		logic    use_rdata;
		status_t status;
	} rsp_ctl_t;

endpackage

>>> src/idt_ram.sv
module idt_ram #(
	parameter int unsigned WIDTH = idt_pkg::DATA_W,
	parameter int unsigned DEPTH = idt_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> src/idt_ctrl.sv
module idt_ctrl #(
	parameter int unsigned DEPTH = idt_pkg::DEPTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [idt_pkg::REQ_W-1:0]    req_type,
	input  logic [idt_pkg::INDEX_W-1:0]  index,
	output logic                         mem_we,
	output logic [AW-1:0]                mem_addr,
	output idt_pkg::rsp_ctl_t            rsp_s1,
	output logic [CW-1:0]                count_s1
);

	// Width wide enough for both the index and the count
	localparam int unsigned MW = (CW > idt_pkg::INDEX_W) ? CW : idt_pkg::INDEX_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;

	logic [MW-1:0] idx_ext;
	logic [MW-1:0] cnt_ext;
	logic          in_range;
	logic          empty;
	logic          full;
	logic [AW-1:0] pos;
	logic [AW:0]   slot_sum;
	logic [AW-1:0] slot;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;

	logic [AW-1:0]     front_d;
	logic [CW-1:0]     count_d;
	idt_pkg::rsp_ctl_t rsp_d;

	assign idx_ext  = MW'(index);
	assign cnt_ext  = MW'(count_q);
	assign in_range = idx_ext < cnt_ext;
	assign empty    = (count_q == '0);
	assign full     = (count_q == DEPTH_C);

	// Position from the front, to be mapped onto a ring slot
	always_comb begin
		case (idt_pkg::req_t'(req_type))
			idt_pkg::REQ_PUSH_BACK: pos = count_q[AW-1:0];
			idt_pkg::REQ_POP_BACK:  pos = AW'(count_q - CW'(1));
			default:                pos = idx_ext[AW-1:0];
		endcase
	end

	// (front + pos) mod DEPTH; both terms are below DEPTH when used
	assign slot_sum = {1'b0, front_q} + {1'b0, pos};
	assign slot     = (slot_sum >= DEPTH_X) ? AW'(slot_sum - DEPTH_X) : slot_sum[AW-1:0];

	// Front pointer steps with wrap
	assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - AW'(1);
	assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + AW'(1);

	// Decode the request, drive the memory port, work out the result
	always_comb begin
		mem_we          = 1'b0;
		mem_addr        = slot;
		front_d         = front_q;
		count_d         = count_q;
		rsp_d.done      = start;
		rsp_d.use_rdata = 1'b0;
		rsp_d.status    = idt_pkg::ST_OK;
		unique case (idt_pkg::req_t'(req_type))
			idt_pkg::REQ_READ: begin
				if (in_range) begin
					rsp_d.use_rdata = 1'b1;
				end else begin
					rsp_d.status = idt_pkg::ST_RANGE;
				end
			end
			idt_pkg::REQ_WRITE: begin
				if (in_range) begin
					mem_we = start;
				end else begin
					rsp_d.status = idt_pkg::ST_RANGE;
				end
			end
			idt_pkg::REQ_PUSH_FRONT: begin
				mem_addr = front_dec;
				if (full) begin
					rsp_d.status = idt_pkg::ST_FULL;
				end else begin
					mem_we  = start;
					front_d = front_dec;
					count_d = count_q + CW'(1);
				end
			end
			idt_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					rsp_d.status = idt_pkg::ST_FULL;
				end else begin
					mem_we  = start;
					count_d = count_q + CW'(1);
				end
			end
			idt_pkg::REQ_POP_FRONT: begin
				mem_addr = front_q;
				if (empty) begin
					rsp_d.status = idt_pkg::ST_EMPTY;
				end else begin
					rsp_d.use_rdata = 1'b1;
					front_d         = front_inc;
					count_d         = count_q - CW'(1);
				end
			end
			idt_pkg::REQ_POP_BACK: begin
				if (empty) begin
					rsp_d.status = idt_pkg::ST_EMPTY;
				end else begin
					rsp_d.use_rdata = 1'b1;
					count_d         = count_q - CW'(1);
				end
			end
			default: begin
				// unused codes: no operation
			end
		endcase
	end

	// Ring pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (start) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	// Result stage, lines up with the RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_s1 <= '0;
		end else begin
			rsp_s1 <= rsp_d;
		end
	end

	always_ff @(posedge clk) begin
		count_s1 <= count_d;
	end

endmodule

>>> src/indexed_deque_table.sv
// Bounded double-ended queue of 64-bit entries with access by position.
// Held as a ring of DEPTH words in one single-port RAM, with a front
// pointer and an entry count in flip-flops.
// Request channel: an item (req_type, index, value) is taken at a rising
// edge where start is high and busy is low. busy stays low: every item
// does exactly one RAM access in the cycle it is taken, and the pointer
// and count are updated at that same edge, so a new item can follow in
// every cycle.
// Result channel: one result item per request, shown on data, status and
// count with done high for exactly one cycle, the cycle after the request
// was taken, at one item per cycle. The RAM's registered read sets that
// delay. The receiver cannot stall the block.
// status: ok, index out of range, list empty, list full; data is zero
// unless a read or pop succeeded. count is the number held afterward.
// Reset (arst_n low) empties the list; RAM contents are not cleared and
// are never read before being written by a push.
module indexed_deque_table #(
	parameter int unsigned DEPTH = idt_pkg::DEPTH_DEF,
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [idt_pkg::REQ_W-1:0]     req_type,
	input  logic [idt_pkg::INDEX_W-1:0]   index,
	input  logic [idt_pkg::DATA_W-1:0]    value,
	output logic                          done,
	output logic [idt_pkg::DATA_W-1:0]    data,
	output logic [idt_pkg::STATUS_W-1:0]  status,
	output logic [CW-1:0]                 count
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic                       accept;
	logic                       mem_we;
	logic [AW-1:0]              mem_addr;
	logic [idt_pkg::DATA_W-1:0] mem_rdata;
	idt_pkg::rsp_ctl_t          rsp_s1;
	logic [CW-1:0]              count_s1;

	// One access per item, so the block never holds off a request
	assign busy   = 1'b0;
	assign accept = start && !busy;

	idt_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.req_type (req_type),
		.index    (index),
		.mem_we   (mem_we),
		.mem_addr (mem_addr),
		.rsp_s1   (rsp_s1),
		.count_s1 (count_s1)
	);

	idt_ram #(
		.WIDTH (idt_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (value),
		.rdata (mem_rdata)
	);

	// Result ports
	assign done   = rsp_s1.done;
	assign data   = rsp_s1.use_rdata ? mem_rdata : '0;
	assign status = rsp_s1.status;
	assign count  = count_s1;

	// Exactly one result follows each accepted item
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("no result after accepted item");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without a request");

	// Reported count never exceeds capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (count <= CW'(DEPTH)))
		else $error("count above capacity");

	// A failed request never returns data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != idt_pkg::ST_OK) |-> (data == '0))
		else $error("data on failed request");

endmodule

>>> sim/tb_indexed_deque_table.sv
`timescale 1ns / 1ps

module tb_indexed_deque_table;

	import idt_pkg::*;

	localparam int unsigned TB_DEPTH = DEPTH_DEF;
	localparam int unsigned CNT_W    = $clog2(TB_DEPTH + 1);
	localparam int unsigned MAX_IDX  = (1 << INDEX_W) - 1;

	// request codes the block treats as no-ops
	localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

	// random phase flavors
	localparam int PH_FILL    = 0;
	localparam int PH_DRAIN   = 1;
	localparam int PH_MIXED   = 2;
	localparam int PH_ACCESS  = 3;

	localparam int unsigned RANDOM_ITEMS = 1530;

	typedef struct {
		logic [REQ_W-1:0]   op;
		logic [INDEX_W-1:0] pos;
		logic [DATA_W-1:0]  word;
		int unsigned        gap;
	} deque_req_t;

	typedef struct {
		logic [DATA_W-1:0] data;
		status_t           status;
		logic [CNT_W-1:0]  count;
	} deque_reply_t;

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 start    = 1'b0;
	logic [REQ_W-1:0]     req_type = '0;
	logic [INDEX_W-1:0]   index    = '0;
	logic [DATA_W-1:0]    value    = '0;
	logic                 busy;
	logic                 done;
	logic [DATA_W-1:0]    data;
	logic [STATUS_W-1:0]  status;
	logic [CNT_W-1:0]     count;

	deque_req_t   requests_to_send[$];
	deque_reply_t replies_due[$];
	int unsigned  mismatch_total = 0;
	int unsigned  gap_count = 0;
	int unsigned  planned_fill = 0;

	// shadow copy of the ring
	logic [DATA_W-1:0] shadow_words [TB_DEPTH];
	int unsigned       shadow_head = 0;
	int unsigned       shadow_fill = 0;

	indexed_deque_table #(
		.DEPTH(TB_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.index    (index),
		.value    (value),
		.done     (done),
		.data     (data),
		.status   (status),
		.count    (count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one request to the shadow ring and work out its reply
	task automatic predict_deque_op(input logic [REQ_W-1:0] op, input logic [INDEX_W-1:0] pos,
			input logic [DATA_W-1:0] word, output deque_reply_t r);
		int unsigned slot;
		r.data   = '0;
		r.status = ST_OK;
		slot = (shadow_head + pos) % TB_DEPTH;
		case (op)
			REQ_READ: begin
				if (pos < shadow_fill) r.data = shadow_words[slot];
				else r.status = ST_RANGE;
			end
			REQ_WRITE: begin
				if (pos < shadow_fill) shadow_words[slot] = word;
				else r.status = ST_RANGE;
			end
			REQ_PUSH_FRONT: begin
				if (shadow_fill >= TB_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_head = (shadow_head + TB_DEPTH - 1) % TB_DEPTH;
					shadow_words[shadow_head] = word;
					shadow_fill++;
				end
			end
			REQ_PUSH_BACK: begin
				if (shadow_fill >= TB_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_words[(shadow_head + shadow_fill) % TB_DEPTH] = word;
					shadow_fill++;
				end
			end
			REQ_POP_FRONT: begin
				if (shadow_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data = shadow_words[shadow_head];
					shadow_head = (shadow_head + 1) % TB_DEPTH;
					shadow_fill--;
				end
			end
			REQ_POP_BACK: begin
				if (shadow_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data = shadow_words[(shadow_head + shadow_fill - 1) % TB_DEPTH];
					shadow_fill--;
				end
			end
			default: ;
		endcase
		r.count = shadow_fill[CNT_W-1:0];
	endtask

	// queue one item and keep a rough fill level for aiming indexes
	task automatic queue_request(input logic [REQ_W-1:0] op, input int unsigned pos,
			input logic [DATA_W-1:0] word, input int unsigned gap);
		deque_req_t q;
		q.op   = op;
		q.pos  = pos[INDEX_W-1:0];
		q.word = word;
		q.gap  = gap;
		requests_to_send.push_back(q);
		if ((op == REQ_PUSH_FRONT || op == REQ_PUSH_BACK) && planned_fill < TB_DEPTH)
			planned_fill++;
		else if ((op == REQ_POP_FRONT || op == REQ_POP_BACK) && planned_fill > 0)
			planned_fill--;
	endtask

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		mismatch_total++;
		$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
	endtask

	// driver: present queued items, honoring each item's lead-in gap
	always @(posedge clk) begin
		deque_req_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			gap_count = 0;
		end else if (!start || !busy) begin
			if (requests_to_send.size() == 0) begin
				start <= 1'b0;
			end else if (gap_count < requests_to_send[0].gap) begin
				gap_count++;
				start <= 1'b0;
			end else begin
				nxt = requests_to_send.pop_front();
				gap_count = 0;
				start    <= 1'b1;
				req_type <= nxt.op;
				index    <= nxt.pos;
				value    <= nxt.word;
			end
		end
	end

	// monitor: predict on accepted items, check each strobed result
	always @(posedge clk) begin
		deque_reply_t want;
		if (arst_n) begin
			if (start && !busy) begin
				predict_deque_op(req_type, index, value, want);
				replies_due.push_back(want);
			end
			if (done) begin
				if (replies_due.size() == 0) begin
					report_mismatch("unexpected result, data", '0, data);
				end else begin
					want = replies_due.pop_front();
					if (data !== want.data)
						report_mismatch("data", want.data, data);
					if (status !== want.status)
						report_mismatch("status", DATA_W'(want.status), DATA_W'(status));
					if (count !== want.count)
						report_mismatch("count", DATA_W'(want.count), DATA_W'(count));
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int unsigned made;
		int unsigned kind;
		int unsigned phase_len;
		int unsigned push_pct, pop_pct, read_pct, write_pct;
		int unsigned r;
		int unsigned pos;
		bit          no_idle;
		logic [REQ_W-1:0]  op;
		logic [DATA_W-1:0] word;
		int unsigned gap;

		// directed: empty list, extremes, every operation, spare codes
		queue_request(REQ_POP_FRONT, 0, '0, 0);
		queue_request(REQ_POP_BACK, MAX_IDX, '1, 0);
		queue_request(REQ_READ, 0, '0, 0);
		queue_request(REQ_WRITE, MAX_IDX, '1, 0);
		queue_request(REQ_PUSH_BACK, 0, '1, 0);
		queue_request(REQ_PUSH_FRONT, 0, '0, 0);
		queue_request(REQ_PUSH_BACK, 0, 64'h5555_5555_5555_5555, 3);
		queue_request(REQ_PUSH_FRONT, 0, 64'hAAAA_AAAA_AAAA_AAAA, 0);
		queue_request(REQ_READ, 0, '0, 0);
		queue_request(REQ_READ, 3, '0, 1);
		queue_request(REQ_READ, 4, '0, 0);
		queue_request(REQ_READ, MAX_IDX, '1, 0);
		queue_request(REQ_WRITE, 1, 64'h8000_0000_0000_0001, 0);
		queue_request(REQ_READ, 1, '0, 0);
		queue_request(REQ_WRITE, 4, '1, 2);
		queue_request(REQ_SPARE_6, MAX_IDX, '1, 0);
		queue_request(REQ_SPARE_7, 0, '0, 0);
		queue_request(REQ_POP_BACK, 0, '0, 0);
		queue_request(REQ_POP_FRONT, 0, '0, 5);
		queue_request(REQ_POP_BACK, 0, '0, 0);
		queue_request(REQ_POP_FRONT, 0, '0, 0);
		queue_request(REQ_POP_BACK, 0, '0, 0);

		// random: phases biased toward filling, draining, mixing or access
		made = 0;
		while (made < RANDOM_ITEMS) begin
			kind      = (made == 0) ? PH_FILL : $urandom_range(PH_FILL, PH_ACCESS);
			phase_len = (made == 0) ? 150 : $urandom_range(20, 120);
			no_idle   = ($urandom_range(0, 3) == 0);
			case (kind)
				PH_FILL:  begin push_pct = 70; pop_pct = 10; read_pct = 10; write_pct = 7; end
				PH_DRAIN: begin push_pct = 10; pop_pct = 70; read_pct = 10; write_pct = 7; end
				PH_MIXED: begin push_pct = 30; pop_pct = 30; read_pct = 20; write_pct = 17; end
				default:  begin push_pct = 15; pop_pct = 15; read_pct = 30; write_pct = 35; end
			endcase
			for (int unsigned k = 0; k < phase_len && made < RANDOM_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < push_pct)
					op = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
				else if (r < push_pct + pop_pct)
					op = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
				else if (r < push_pct + pop_pct + read_pct)
					op = REQ_READ;
				else if (r < push_pct + pop_pct + read_pct + write_pct)
					op = REQ_WRITE;
				else
					op = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;

				// aim indexes inside the list and at its end as well as anywhere
				case ($urandom_range(0, 3))
					1: pos = (planned_fill > 0) ? $urandom_range(0, planned_fill - 1)
						: $urandom_range(0, MAX_IDX);
					2: begin
						pos = planned_fill + $urandom_range(0, 2);
						pos = (pos == 0) ? 0 : pos - 1;
						if (pos > MAX_IDX) pos = MAX_IDX;
					end
					default: pos = $urandom_range(0, MAX_IDX);
				endcase

				case ($urandom_range(0, 7))
					0: word = '1;
					1: word = '0;
					default: word = {$urandom, $urandom};
				endcase

				gap = (no_idle || $urandom_range(0, 1)) ? 0 : $urandom_range(1, 18);
				queue_request(op, pos, word, gap);
				made++;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// drain, then give the registered result path time to show strays
		while (requests_to_send.size() != 0 || start || replies_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		if (mismatch_total == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
